/* sv/tpf_pkg.sv */
// Package for the typed packet framer: transaction structs, command format,
// type table and byte constants. No dependencies.
package tpf_pkg;

  // Input transaction
  typedef struct packed {
    logic       op;
    logic [3:0] data_type;
    logic [7:0] element_count;
    logic [7:0] data_byte;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [7:0] byte_out;
    logic       valid_byte;
    logic       last;
    logic [2:0] error_code;
  } out_item_t;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Error codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_TYPE  = 3'd1;
  localparam logic [2:0] ERR_LONG  = 3'd2;
  localparam logic [2:0] ERR_NOPKT = 3'd3;
  localparam logic [2:0] ERR_OPEN  = 3'd4;

  // Framing bytes
  localparam logic [7:0] CH_K  = 8'h4B;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Largest payload in bytes and highest valid element type
  localparam int unsigned MAX_PAYLOAD = 248;
  localparam logic [3:0]  LAST_TYPE   = 4'd9;

  // Byte count width: 8-bit count shifted by up to three
  localparam int unsigned NB_W = 11;

  // Command queue depth
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    CMD_ERR,
    CMD_HDR,
    CMD_DATA
  } cmd_kind_t;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic       trailer;   // append sequence number, CR, LF
    logic [7:0] byte_val;  // payload byte or low info byte
    logic [7:0] code_hi;   // high info byte
    logic [15:0] seq;
    logic [2:0] err;
  } cmd_t;

  // Element size shift per type
  function automatic logic [1:0] type_shift(input logic [3:0] t);
    logic [1:0] s;
    case (t)
      4'd8:    s = 2'd2;
      4'd9:    s = 2'd3;
      default: s = t[1:0];
    endcase
    return s;
  endfunction

  // High nibble of the info word per type
  function automatic logic [3:0] type_nibble(input logic [3:0] t);
    logic [3:0] n;
    case (t)
      4'd8:    n = 4'hA;
      4'd9:    n = 4'hB;
      default: n = t;
    endcase
    return n;
  endfunction

endpackage

/* sv/tpf_front.sv */
// Front end of the typed packet framer: accepts input transactions, checks
// them against packet state and issues commands. Depends on tpf_pkg.
module tpf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  tpf_pkg::in_item_t in_item,
  output logic             in_ready,
  input  logic             q_full,
  output logic             push,
  output tpf_pkg::cmd_t    push_cmd
);

  logic [15:0]             seq_r, seq_nxt;
  logic [7:0]              left_r, left_nxt;
  logic                    open_r, open_nxt;
  logic [tpf_pkg::NB_W-1:0] nbytes;
  logic [7:0]              left_dec;
  logic [15:0]             seq_inc;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign seq_inc  = seq_r + 16'd1;
  assign left_dec = left_r - 8'd1;
  assign nbytes   = {{(tpf_pkg::NB_W-8){1'b0}}, in_item.element_count}
                    << tpf_pkg::type_shift(in_item.data_type);

  // Classify the transaction and work out the next packet state
  always_comb begin
    seq_nxt           = seq_r;
    left_nxt          = left_r;
    open_nxt          = open_r;
    push_cmd.kind     = tpf_pkg::CMD_ERR;
    push_cmd.trailer  = 1'b0;
    push_cmd.byte_val = in_item.data_byte;
    push_cmd.code_hi  = {tpf_pkg::type_nibble(in_item.data_type), 4'h0};
    push_cmd.seq      = seq_r;
    push_cmd.err      = tpf_pkg::ERR_OK;
    if (in_item.op == tpf_pkg::OP_START) begin
      if (open_r) begin
        push_cmd.err = tpf_pkg::ERR_OPEN;
      end else if (in_item.data_type > tpf_pkg::LAST_TYPE) begin
        push_cmd.err = tpf_pkg::ERR_TYPE;
      end else if (nbytes > tpf_pkg::NB_W'(tpf_pkg::MAX_PAYLOAD)) begin
        push_cmd.err = tpf_pkg::ERR_LONG;
      end else begin
        push_cmd.kind     = tpf_pkg::CMD_HDR;
        push_cmd.byte_val = nbytes[7:0];
        push_cmd.seq      = seq_inc;
        push_cmd.trailer  = (nbytes == '0);
        seq_nxt           = seq_inc;
        if (nbytes != '0) begin
          open_nxt = 1'b1;
          left_nxt = nbytes[7:0];
        end
      end
    end else begin
      if (!open_r) begin
        push_cmd.err = tpf_pkg::ERR_NOPKT;
      end else begin
        push_cmd.kind    = tpf_pkg::CMD_DATA;
        push_cmd.trailer = (left_dec == 8'd0);
        left_nxt         = left_dec;
        if (left_dec == 8'd0) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  // Advance packet state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      left_r <= '0;
      open_r <= 1'b0;
    end else if (push) begin
      seq_r  <= seq_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

/* sv/tpf_queue.sv */
// Command queue between the framer front and back ends.
// Small register file with head and tail pointers. Depends on tpf_pkg.
module tpf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tpf_pkg::cmd_t head_cmd
);

  tpf_pkg::cmd_t            mem [tpf_pkg::Q_DEPTH];
  logic [tpf_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [tpf_pkg::Q_AW:0]   cnt_r;

  assign full       = (cnt_r == (tpf_pkg::Q_AW+1)'(tpf_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* sv/tpf_back.sv */
// Back end of the typed packet framer: expands each queued command into
// output results, one per cycle while out_ready allows, into an output register. Depends on tpf_pkg.
module tpf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  tpf_pkg::cmd_t     head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tpf_pkg::out_item_t out_item
);

  logic [2:0]         step_r;
  logic               out_valid_r;
  tpf_pkg::out_item_t out_item_r;
  tpf_pkg::out_item_t cur;
  logic [1:0]         tidx;
  logic [7:0]         tbyte;
  logic               load;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign load      = head_valid && (!out_valid_r || out_ready);

  // Pick the trailer byte for the current step
  always_comb begin
    if (head_cmd.kind == tpf_pkg::CMD_HDR) begin
      tidx = step_r[1:0];
    end else begin
      tidx = 2'(step_r - 3'd1);
    end
    case (tidx)
      2'd0:    tbyte = head_cmd.seq[7:0];
      2'd1:    tbyte = head_cmd.seq[15:8];
      2'd2:    tbyte = tpf_pkg::CH_CR;
      default: tbyte = tpf_pkg::CH_LF;
    endcase
  end

  // Build the byte for the current step of the head command
  always_comb begin
    cur.byte_out   = 8'd0;
    cur.valid_byte = 1'b1;
    cur.last       = 1'b0;
    cur.error_code = tpf_pkg::ERR_OK;
    case (head_cmd.kind)
      tpf_pkg::CMD_HDR: begin
        case (step_r)
          3'd0:    cur.byte_out = tpf_pkg::CH_K;
          3'd1:    cur.byte_out = tpf_pkg::CH_S;
          3'd2:    cur.byte_out = head_cmd.byte_val;
          3'd3:    cur.byte_out = head_cmd.code_hi;
          default: cur.byte_out = tbyte;
        endcase
        cur.last = head_cmd.trailer ? (step_r == 3'd7) : (step_r == 3'd3);
      end
      tpf_pkg::CMD_DATA: begin
        cur.byte_out = (step_r == 3'd0) ? head_cmd.byte_val : tbyte;
        cur.last     = head_cmd.trailer ? (step_r == 3'd4) : (step_r == 3'd0);
      end
      default: begin
        cur.valid_byte = 1'b0;
        cur.last       = 1'b1;
        cur.error_code = head_cmd.err;
      end
    endcase
  end

  assign pop = load && cur.last;

  // Advance the step counter and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      step_r      <= cur.last ? 3'd0 : step_r + 3'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold payload until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= cur;
    end
  end

endmodule

/* sv/typed_packet_framer_top.sv */
// Typed packet framer top level: front end, command queue and back end.
// Depends on tpf_pkg, tpf_front, tpf_queue and tpf_back.
//
// A start transaction opens a packet and produces 'K', 'S' and the 16-bit
// info word low byte first (plus sequence number, CR and LF at once when the
// byte count is zero); each payload transaction produces its byte, and the
// last one also the trailer. Errors produce one flagged result. The front end
// accepts one transaction per cycle while the four-entry command queue has
// room; the back end emits one byte per cycle while out_ready allows, so a start
// yields four or eight output results, a payload byte one or five, an error
// one. Sustained rate is set by the back end's byte sequencer; the first byte
// passes through the command queue and is offered from the output register.
module typed_packet_framer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output tpf_pkg::out_item_t out_item
);

  logic          q_full;
  logic          push;
  tpf_pkg::cmd_t push_cmd;
  logic          pop;
  logic          head_valid;
  tpf_pkg::cmd_t head_cmd;

  tpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

/* test/tpf_check_pkg.sv */
// Scoreboard for the typed packet framer: predicts the framed byte stream for
// each accepted input transaction and checks results in order.
// Depends on tpf_pkg.
package tpf_check_pkg;
  import tpf_pkg::*;

  // Per-type info nibble and element size shift
  localparam logic [3:0] TYPE_NIBBLE [10] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4,
                                              4'h5, 4'h6, 4'h7, 4'hA, 4'hB};
  localparam logic [1:0] TYPE_SHIFT [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0,
                                             2'd1, 2'd2, 2'd3, 2'd2, 2'd3};

  class framer_scoreboard;
    logic [15:0] seq_num;
    logic [7:0]  bytes_left;
    logic        pkt_open;
    out_item_t   frame_q[$];
    int unsigned mismatches;
    int unsigned packets;
    int unsigned flagged;
    int unsigned results;

    function new();
      seq_num = '0;
      bytes_left = '0;
      pkt_open = 1'b0;
      mismatches = 0;
      packets = 0;
      flagged = 0;
      results = 0;
    endfunction

    // Payload size in bytes for a valid type
    function int unsigned payload_len(logic [3:0] t, logic [7:0] cnt);
      return int'(cnt) << TYPE_SHIFT[t];
    endfunction

    function int unsigned pending();
      return frame_q.size();
    endfunction

    function void push_byte(logic [7:0] b);
      out_item_t r;
      r.byte_out = b;
      r.valid_byte = 1'b1;
      r.last = 1'b0;
      r.error_code = ERR_OK;
      frame_q.push_back(r);
    endfunction

    function void push_flag(logic [2:0] code);
      out_item_t r;
      r.byte_out = 8'h00;
      r.valid_byte = 1'b0;
      r.last = 1'b1;
      r.error_code = code;
      frame_q.push_back(r);
      flagged++;
    endfunction

    // Sequence number low byte first, then CR LF; close the packet
    function void push_trailer();
      push_byte(seq_num[7:0]);
      push_byte(seq_num[15:8]);
      push_byte(CH_CR);
      push_byte(CH_LF);
      pkt_open = 1'b0;
      bytes_left = '0;
    endfunction

    function void mark_last();
      out_item_t tail;
      tail = frame_q.pop_back();
      tail.last = 1'b1;
      frame_q.push_back(tail);
    endfunction

    // Predict the results of one accepted input transaction
    function void note_input(in_item_t it);
      int unsigned nbytes;
      logic [15:0] info;
      if (it.op == OP_START) begin
        if (pkt_open) begin
          push_flag(ERR_OPEN);
        end else if (it.data_type > LAST_TYPE) begin
          push_flag(ERR_TYPE);
        end else begin
          nbytes = payload_len(it.data_type, it.element_count);
          if (nbytes > MAX_PAYLOAD) begin
            push_flag(ERR_LONG);
          end else begin
            info = {TYPE_NIBBLE[it.data_type], 12'h000} | 16'(nbytes);
            seq_num = seq_num + 16'd1;
            packets++;
            push_byte(CH_K);
            push_byte(CH_S);
            push_byte(info[7:0]);
            push_byte(info[15:8]);
            if (nbytes == 0) begin
              push_trailer();
            end else begin
              pkt_open = 1'b1;
              bytes_left = 8'(nbytes);
            end
            mark_last();
          end
        end
      end else if (!pkt_open) begin
        push_flag(ERR_NOPKT);
      end else begin
        push_byte(it.data_byte);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
          push_trailer();
        end
        mark_last();
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (frame_q.size() == 0) begin
        $error("unexpected result: byte_out %02h valid_byte %0d error_code %0d",
               got.byte_out, got.valid_byte, got.error_code);
        mismatches++;
        return;
      end
      want = frame_q.pop_front();
      results++;
      if (got.byte_out !== want.byte_out) begin
        $error("byte_out: expected %02h, got %02h", want.byte_out, got.byte_out);
        mismatches++;
      end
      if (got.valid_byte !== want.valid_byte) begin
        $error("valid_byte: expected %0d, got %0d", want.valid_byte, got.valid_byte);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* test/tb.sv */
// Testbench for typed_packet_framer_top: directed and random framing traffic
// under several idle and stall patterns. Depends on tpf_pkg, tpf_check_pkg
// and the framer RTL.
module tb;
  import tpf_pkg::*;
  import tpf_check_pkg::*;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  framer_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned sent_items = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  typed_packet_framer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input transactions, check output transactions, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_item);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_item);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("typed_packet_framer_top test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_item_t start_cmd(logic [3:0] t, logic [7:0] cnt);
    in_item_t it;
    it.op = OP_START;
    it.data_type = t;
    it.element_count = cnt;
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t data_cmd(logic [7:0] b);
    in_item_t it;
    it.op = OP_DATA;
    it.data_type = 4'($urandom);
    it.element_count = 8'($urandom);
    it.data_byte = b;
    return it;
  endfunction

  // Offer one transaction, idling first at random, and hold it until accepted
  task automatic send_item(input in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // Well-formed packet; nested starts are mixed in at noise_pct percent
  task automatic send_packet(input logic [3:0] t, input logic [7:0] cnt,
                             input int unsigned noise_pct);
    int unsigned n;
    n = sb.payload_len(t, cnt);
    send_item(start_cmd(t, cnt));
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_item(start_cmd(4'($urandom), 8'($urandom)));
      end
      send_item(data_cmd(8'($urandom)));
    end
  endtask

  // Stray byte, bad type or oversize start between packets
  task automatic send_noise();
    logic [3:0] t;
    t = 4'($urandom_range(LAST_TYPE));
    case ($urandom_range(2))
      0: send_item(data_cmd(8'($urandom)));
      1: send_item(start_cmd(4'($urandom_range(15, 10)), 8'($urandom)));
      default: send_item(start_cmd(t, 8'($urandom_range(255,
                         (MAX_PAYLOAD >> TYPE_SHIFT[t]) + 1))));
    endcase
  endtask

  // Short packets of any type, at most 12 payload bytes
  task automatic send_short_packet();
    logic [3:0] t;
    t = 4'($urandom_range(LAST_TYPE));
    send_packet(t, 8'($urandom_range(12 >> TYPE_SHIFT[t])), 8);
  endtask

  initial begin
    logic [3:0] big_type;
    int unsigned phase_end;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: error paths, empty packets, full-width count, nested start
    send_item(data_cmd(8'hA5));
    send_item(start_cmd(4'd0, 8'd0));
    send_item(start_cmd(4'd10, 8'd1));
    send_item(start_cmd(4'd15, 8'd255));
    send_item(start_cmd(4'd0, 8'd249));
    send_item(start_cmd(4'd3, 8'd32));
    send_item(start_cmd(4'd9, 8'd255));
    send_item(start_cmd(4'd8, 8'd0));
    send_item(start_cmd(4'd9, 8'd0));
    send_item(start_cmd(4'd7, 8'd1));
    send_item(data_cmd(8'h00));
    send_item(start_cmd(4'd0, 8'd0));
    send_item(data_cmd(8'hFF));
    repeat (6) send_item(data_cmd(8'($urandom)));
    send_item(data_cmd(8'h3C));

    // Random traffic over the idle phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 50;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 50;
        end
        default: begin
          send_idle_pct = 16;
          recv_stall_pct = 16;
        end
      endcase
      if (ph == 0) begin
        // one longer packet of 32 payload bytes
        big_type = 4'($urandom_range(LAST_TYPE));
        send_packet(big_type, 8'(32 >> TYPE_SHIFT[big_type]), 0);
      end
      if (ph == 2) begin
        // hold off the receiver while the sender keeps pushing
        hold_asks++;
        send_packet(4'd0, 8'd20, 0);
      end
      phase_end = sent_items + RANDOM_ITEMS / 4;
      while (sent_items < phase_end) begin
        if ($urandom_range(99) < 20) begin
          send_noise();
        end else begin
          send_short_packet();
        end
      end
    end
    in_valid <= 1'b0;

    // Drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input transactions: %0d packets framed, %0d flagged.",
             sent_items, sb.packets, sb.flagged);
    $display("Checked %0d results across four idle patterns and one long hold-off.",
             sb.results);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("typed_packet_framer_top test passed");
    end else begin
      $display("typed_packet_framer_top test failed");
    end
    $finish;
  end

endmodule
